// ===== rtl/hfmr_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the framed message receiver.
package hfmr_pkg;

  localparam int COUNT_BITS = 10;
  localparam int MAXLEN_W   = 10;
  localparam int LIMIT_W    = 8;
  localparam int CMP_W      = (COUNT_BITS > MAXLEN_W) ? COUNT_BITS : MAXLEN_W;
  localparam int BADRUN_W   = 9;

  localparam logic [7:0]  BYTE_FLAG     = 8'h7E;
  localparam logic [7:0]  BYTE_ESC      = 8'h7D;
  localparam logic [7:0]  ESC_XOR       = 8'h20;
  localparam logic [7:0]  PROTO_BYTE    = 8'h45;
  localparam logic [7:0]  DISPATCH_BYTE = 8'h00;
  localparam logic [15:0] CRC_POLY      = 16'h1021;

  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = MAXLEN_W'(1000);
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(100);

  // Byte positions inside a frame.
  localparam int POS_PROTO    = 0;
  localparam int POS_DISPATCH = 1;
  localparam int POS_DEST_HI  = 2;
  localparam int POS_DEST_LO  = 3;
  localparam int POS_SRC_HI   = 4;
  localparam int POS_SRC_LO   = 5;
  localparam int POS_LEN      = 6;
  localparam int POS_GROUP    = 7;
  localparam int POS_TYPE     = 8;
  localparam int POS_PAYLOAD  = 11;  // bytes leave the delay line two positions late
  localparam int MIN_CRC_LEN  = 3;
  localparam int HDR_OVERHEAD = 11;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_LIMIT = 1'b1;
  localparam int CFG_DATA_W = 10;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_FORMAT = 3'd1;
  localparam logic [2:0] ST_BAD_CRC    = 3'd2;
  localparam logic [2:0] ST_NOT_MSG    = 3'd3;
  localparam logic [2:0] ST_BAD_LEN    = 3'd4;
  localparam logic [2:0] ST_OVERLONG   = 3'd5;
  localparam logic [2:0] ST_TOO_MANY   = 3'd6;

  typedef enum logic [1:0] {
    OP_PLAIN = 2'd0,
    OP_ESCAPED = 2'd1,
    OP_FLAG = 2'd2
  } hfmr_op_t;

  typedef struct packed {
    hfmr_op_t   op;
    logic [7:0] data;
  } hfmr_cmd_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  frame_status;
    logic [15:0] dest_addr;
    logic [15:0] source_addr;
    logic [7:0]  group_id;
    logic [7:0]  msg_type;
    logic [7:0]  payload_length;
    logic        last;
  } hfmr_result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/hfmr_front.sv =====
// Front end: removes byte stuffing, classifies line bytes and queues them as requests.
module hfmr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [7:0]        in_rx_byte,
  output logic              in_full,
  output logic              cmd_valid,
  output hfmr_pkg::hfmr_cmd_t cmd,
  input  logic              cmd_ready
);
  import hfmr_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  hfmr_cmd_t        q_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             escape_r, escape_nxt;
  logic             enq, deq, take;
  hfmr_cmd_t        enq_cmd;

  assign in_full   = (count_r == (PTR_W+1)'(DEPTH));
  assign take      = in_push && !in_full;
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rptr_r];
  assign deq       = cmd_valid && cmd_ready;

  always_comb begin
    escape_nxt   = escape_r;
    enq          = 1'b0;
    enq_cmd.op   = OP_PLAIN;
    enq_cmd.data = in_rx_byte;
    if (take) begin
      if (escape_r) begin
        escape_nxt   = 1'b0;
        enq          = 1'b1;
        enq_cmd.op   = OP_ESCAPED;
        enq_cmd.data = in_rx_byte ^ ESC_XOR;
      end else if (in_rx_byte == BYTE_ESC) begin
        escape_nxt = 1'b1;
      end else if (in_rx_byte == BYTE_FLAG) begin
        enq        = 1'b1;
        enq_cmd.op = OP_FLAG;
      end else begin
        enq = 1'b1;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (enq && !deq) begin
      count_nxt = count_r + 1'b1;
    end else if (!enq && deq) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r <= 1'b0;
      wptr_r   <= '0;
      rptr_r   <= '0;
      count_r  <= '0;
    end else begin
      escape_r <= escape_nxt;
      count_r  <= count_nxt;
      if (enq) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (deq) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wptr_r] <= enq_cmd;
    end
  end

endmodule

// ===== rtl/hfmr_back.sv =====
// Back end: frame assembly, CRC check, header decode, error counting and the result queue.
module hfmr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  hfmr_pkg::hfmr_cmd_t           cmd,
  output logic                          cmd_ready,
  input  logic                          cfg_valid,
  input  logic [hfmr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hfmr_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          res_empty,
  input  logic                          res_pop,
  output hfmr_pkg::hfmr_result_t        res
);
  import hfmr_pkg::*;

  logic [MAXLEN_W-1:0]   max_len_r;
  logic [LIMIT_W-1:0]    limit_r;

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [15:0]           crc_r, crc_nxt;
  logic [7:0]            d0_r, d0_nxt, d1_r, d1_nxt;
  logic [15:0]           dest_r, dest_nxt, src_r, src_nxt;
  logic [7:0]            len_r, len_nxt, grp_r, grp_nxt, typ_r, typ_nxt;
  logic                  proto_r, proto_nxt, disp_r, disp_nxt;
  // Bad frame run count held biased by one so that reset is zero.
  logic [BADRUN_W-1:0]   badrun_r, badrun_nxt;
  logic                  disc_r, disc_nxt;

  hfmr_result_t          oq_r [2];
  logic                  owptr_r, orptr_r;
  logic [1:0]            ocount_r, ocount_nxt;

  logic                  take, emit;
  hfmr_result_t          r;
  logic [15:0]           crc_a, crc_fin;
  logic [2:0]            st;
  logic                  bad;
  logic [2:0]            bad_code;

  assign cmd_ready = (ocount_r != 2'd2);
  assign take      = cmd_valid && cmd_ready;

  assign crc_a   = crc_byte(crc_r, d1_r);
  assign crc_fin = crc_byte(crc_a, d0_r);

  // End of frame status, before the bad run count is applied.
  always_comb begin
    bad      = 1'b0;
    bad_code = ST_BAD_FORMAT;
    st       = ST_OK;
    if (cnt_r < COUNT_BITS'(MIN_CRC_LEN) || !proto_r) begin
      bad      = 1'b1;
      bad_code = ST_BAD_FORMAT;
    end else if (crc_fin != 16'h0000) begin
      bad      = 1'b1;
      bad_code = ST_BAD_CRC;
    end else if (cnt_r < COUNT_BITS'(HDR_OVERHEAD) || !disp_r) begin
      st = ST_NOT_MSG;
    end else if ({1'b0, cnt_r} != (COUNT_BITS+1)'(len_r) + (COUNT_BITS+1)'(HDR_OVERHEAD)) begin
      st = ST_BAD_LEN;
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    d0_nxt     = d0_r;
    d1_nxt     = d1_r;
    dest_nxt   = dest_r;
    src_nxt    = src_r;
    len_nxt    = len_r;
    grp_nxt    = grp_r;
    typ_nxt    = typ_r;
    proto_nxt  = proto_r;
    disp_nxt   = disp_r;
    badrun_nxt = badrun_r;
    disc_nxt   = disc_r;
    emit       = 1'b0;
    r          = '0;

    if (take && !disc_r) begin
      if (cmd.op == OP_FLAG) begin
        if (cnt_r != '0) begin
          emit        = 1'b1;
          r.item_kind = KIND_STATUS;
          r.last      = 1'b1;
          if (bad) begin
            if (CMP_W'(badrun_r) > CMP_W'(limit_r) || badrun_r > BADRUN_W'(limit_r)) begin
              disc_nxt       = 1'b1;
              r.frame_status = ST_TOO_MANY;
            end else begin
              r.frame_status = bad_code;
            end
            badrun_nxt = badrun_r + 1'b1;
          end else begin
            badrun_nxt     = BADRUN_W'(1);
            r.frame_status = st;
            if (st == ST_OK) begin
              r.dest_addr      = dest_r;
              r.source_addr    = src_r;
              r.group_id       = grp_r;
              r.msg_type       = typ_r;
              r.payload_length = len_r;
            end
          end
          cnt_nxt   = '0;
          crc_nxt   = '0;
          d0_nxt    = '0;
          d1_nxt    = '0;
          dest_nxt  = '0;
          src_nxt   = '0;
          len_nxt   = '0;
          grp_nxt   = '0;
          typ_nxt   = '0;
          proto_nxt = 1'b0;
          disp_nxt  = 1'b0;
        end
      end else if (cmd.op == OP_PLAIN && CMP_W'(cnt_r) > CMP_W'(max_len_r)) begin
        disc_nxt       = 1'b1;
        emit           = 1'b1;
        r.item_kind    = KIND_STATUS;
        r.frame_status = ST_OVERLONG;
        r.last         = 1'b1;
        cnt_nxt        = '0;
        crc_nxt        = '0;
        d0_nxt         = '0;
        d1_nxt         = '0;
        dest_nxt       = '0;
        src_nxt        = '0;
        len_nxt        = '0;
        grp_nxt        = '0;
        typ_nxt        = '0;
        proto_nxt      = 1'b0;
        disp_nxt       = 1'b0;
      end else begin
        case (cnt_r)
          COUNT_BITS'(POS_PROTO):    proto_nxt       = (cmd.data == PROTO_BYTE);
          COUNT_BITS'(POS_DISPATCH): disp_nxt        = (cmd.data == DISPATCH_BYTE);
          COUNT_BITS'(POS_DEST_HI):  dest_nxt[15:8]  = cmd.data;
          COUNT_BITS'(POS_DEST_LO):  dest_nxt[7:0]   = cmd.data;
          COUNT_BITS'(POS_SRC_HI):   src_nxt[15:8]   = cmd.data;
          COUNT_BITS'(POS_SRC_LO):   src_nxt[7:0]    = cmd.data;
          COUNT_BITS'(POS_LEN):      len_nxt         = cmd.data;
          COUNT_BITS'(POS_GROUP):    grp_nxt         = cmd.data;
          COUNT_BITS'(POS_TYPE):     typ_nxt         = cmd.data;
          default: ;
        endcase
        if (cnt_r == COUNT_BITS'(0)) begin
          d0_nxt = cmd.data;
        end else if (cnt_r == COUNT_BITS'(1)) begin
          d1_nxt = cmd.data;
        end else begin
          crc_nxt = crc_byte(crc_r, d0_r);
          d0_nxt  = d1_r;
          d1_nxt  = cmd.data;
          if (cnt_r >= COUNT_BITS'(POS_PAYLOAD)) begin
            emit           = 1'b1;
            r.item_kind    = KIND_PAYLOAD;
            r.payload_byte = d0_r;
          end
        end
        if (cnt_r != '1) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    ocount_nxt = ocount_r;
    if (emit && !(res_pop && !res_empty)) begin
      ocount_nxt = ocount_r + 1'b1;
    end else if (!emit && res_pop && !res_empty) begin
      ocount_nxt = ocount_r - 1'b1;
    end
  end

  assign res_empty = (ocount_r == 2'd0);
  assign res       = oq_r[orptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAXLEN_RESET;
      limit_r   <= LIMIT_RESET;
      cnt_r     <= '0;
      crc_r     <= '0;
      d0_r      <= '0;
      d1_r      <= '0;
      dest_r    <= '0;
      src_r     <= '0;
      len_r     <= '0;
      grp_r     <= '0;
      typ_r     <= '0;
      proto_r   <= 1'b0;
      disp_r    <= 1'b0;
      badrun_r  <= '0;
      disc_r    <= 1'b0;
      owptr_r   <= 1'b0;
      orptr_r   <= 1'b0;
      ocount_r  <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MAX_LEN:   max_len_r <= cfg_data[MAXLEN_W-1:0];
          CFG_BAD_LIMIT: limit_r   <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      cnt_r    <= cnt_nxt;
      crc_r    <= crc_nxt;
      d0_r     <= d0_nxt;
      d1_r     <= d1_nxt;
      dest_r   <= dest_nxt;
      src_r    <= src_nxt;
      len_r    <= len_nxt;
      grp_r    <= grp_nxt;
      typ_r    <= typ_nxt;
      proto_r  <= proto_nxt;
      disp_r   <= disp_nxt;
      badrun_r <= badrun_nxt;
      disc_r   <= disc_nxt;
      ocount_r <= ocount_nxt;
      if (emit) begin
        owptr_r <= ~owptr_r;
      end
      if (res_pop && !res_empty) begin
        orptr_r <= ~orptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oq_r[owptr_r] <= r;
    end
  end

endmodule

// ===== rtl/hdlc_framed_message_receiver_core.sv =====
// Top level of the framed message receiver: front end, request queue and back end.
// Throughput: one line byte per cycle sustained; in_full rises only while results are not popped.
// A byte accepted from the line waits in the front request queue until the back end takes it;
// results are registered in the result queue as bytes are taken, and show on out_ until popped.
// Reset (synchronous, rst_n low) empties both queues, clears frame state and the escape flag,
// restores the register defaults and sets the bad frame run to minus one.
module hdlc_framed_message_receiver_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  logic [7:0]                      in_rx_byte,
  output logic                            in_full,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic                            out_item_kind,
  output logic [7:0]                      out_payload_byte,
  output logic [2:0]                      out_frame_status,
  output logic [15:0]                     out_dest_addr,
  output logic [15:0]                     out_source_addr,
  output logic [7:0]                      out_group_id,
  output logic [7:0]                      out_msg_type,
  output logic [7:0]                      out_payload_length,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hfmr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hfmr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hfmr_pkg::*;

  logic         cmd_valid, cmd_ready;
  hfmr_cmd_t    cmd;
  hfmr_result_t res;

  assign cfg_ready = 1'b1;

  hfmr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_rx_byte(in_rx_byte),
    .in_full   (in_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  hfmr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_ready(cmd_ready),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .res_empty(out_empty),
    .res_pop  (out_pop),
    .res      (res)
  );

  assign out_item_kind      = res.item_kind;
  assign out_payload_byte   = res.payload_byte;
  assign out_frame_status   = res.frame_status;
  assign out_dest_addr      = res.dest_addr;
  assign out_source_addr    = res.source_addr;
  assign out_group_id       = res.group_id;
  assign out_msg_type       = res.msg_type;
  assign out_payload_length = res.payload_length;
  assign out_last           = res.last;

endmodule

// ===== tb/sv/hdlc_framed_message_receiver_core_tb.sv =====
// Self-checking testbench for the framed message receiver core with its own frame predictor.
module hdlc_framed_message_receiver_core_tb;
  import hfmr_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int COUNT_TOP     = (1 << COUNT_BITS) - 1;
  localparam int RANDOM_BYTES  = 650;
  localparam int NO_FORCED_ESC = 1 << 30;

  typedef logic [7:0] byte_q_t[$];

  typedef enum int {
    SHAPE_GOOD,
    SHAPE_NOT_MSG,
    SHAPE_SHORT,
    SHAPE_BAD_LEN,
    SHAPE_BAD_CRC,
    SHAPE_BAD_PROTO,
    SHAPE_NOISE,
    SHAPE_EMPTY
  } shape_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_push    = 1'b0;
  logic [7:0]            in_rx_byte = 8'h00;
  logic                  in_full;
  logic                  out_empty;
  logic                  out_pop    = 1'b0;
  logic                  out_item_kind;
  logic [7:0]            out_payload_byte;
  logic [2:0]            out_frame_status;
  logic [15:0]           out_dest_addr;
  logic [15:0]           out_source_addr;
  logic [7:0]            out_group_id;
  logic [7:0]            out_msg_type;
  logic [7:0]            out_payload_length;
  logic                  out_last;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // Predicted receiver state and register copies.
  int          p_max_len;
  int          p_limit;
  logic        p_esc;
  int          p_count;
  logic [7:0]  p_dly[2];
  logic [15:0] p_crc;
  logic [15:0] p_dest;
  logic [15:0] p_src;
  logic [7:0]  p_len;
  logic [7:0]  p_grp;
  logic [7:0]  p_typ;
  logic        p_proto_ok;
  logic        p_disp_ok;
  int          p_bad_run;
  logic        p_disc;

  hfmr_result_t pending_results[$];
  hfmr_result_t got_item;
  hfmr_result_t want_item;
  int           fail_count = 0;
  int           cycles     = 0;
  int           sent_bytes = 0;
  int           stall_left = 0;
  bit           in_calm    = 1'b0;
  bit           out_calm   = 1'b0;

  hdlc_framed_message_receiver_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_rx_byte         (in_rx_byte),
    .in_full            (in_full),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_item_kind      (out_item_kind),
    .out_payload_byte   (out_payload_byte),
    .out_frame_status   (out_frame_status),
    .out_dest_addr      (out_dest_addr),
    .out_source_addr    (out_source_addr),
    .out_group_id       (out_group_id),
    .out_msg_type       (out_msg_type),
    .out_payload_length (out_payload_length),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bitwise CRC-16, polynomial 0x1021, MSB first.
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic void clear_frame();
    p_count    = 0;
    p_dly[0]   = 8'h00;
    p_dly[1]   = 8'h00;
    p_crc      = 16'h0000;
    p_dest     = 16'h0000;
    p_src      = 16'h0000;
    p_len      = 8'h00;
    p_grp      = 8'h00;
    p_typ      = 8'h00;
    p_proto_ok = 1'b0;
    p_disp_ok  = 1'b0;
  endfunction

  function automatic void reset_model();
    p_max_len = MAXLEN_RESET;
    p_limit   = LIMIT_RESET;
    p_esc     = 1'b0;
    p_bad_run = -1;
    p_disc    = 1'b0;
    clear_frame();
    pending_results.delete();
  endfunction

  function automatic void add_payload(input logic [7:0] b);
    hfmr_result_t r;
    r              = '0;
    r.item_kind    = KIND_PAYLOAD;
    r.payload_byte = b;
    pending_results.push_back(r);
  endfunction

  function automatic void add_status(input logic [2:0] st);
    hfmr_result_t r;
    r              = '0;
    r.item_kind    = KIND_STATUS;
    r.frame_status = st;
    r.last         = 1'b1;
    if (st == ST_OK) begin
      r.dest_addr      = p_dest;
      r.source_addr    = p_src;
      r.group_id       = p_grp;
      r.msg_type       = p_typ;
      r.payload_length = p_len;
    end
    pending_results.push_back(r);
  endfunction

  // The two newest bytes are held back, since they may turn out to be the CRC.
  function automatic void append_unstuffed(input logic [7:0] b);
    int idx;
    idx = p_count;
    case (idx)
      POS_PROTO:    p_proto_ok = (b == PROTO_BYTE);
      POS_DISPATCH: p_disp_ok = (b == DISPATCH_BYTE);
      POS_DEST_HI:  p_dest[15:8] = b;
      POS_DEST_LO:  p_dest[7:0] = b;
      POS_SRC_HI:   p_src[15:8] = b;
      POS_SRC_LO:   p_src[7:0] = b;
      POS_LEN:      p_len = b;
      POS_GROUP:    p_grp = b;
      POS_TYPE:     p_typ = b;
      default: ;
    endcase
    if (idx >= 2) begin
      p_crc = crc16_next(p_crc, p_dly[0]);
      if (idx >= POS_PAYLOAD) add_payload(p_dly[0]);
      p_dly[0] = p_dly[1];
      p_dly[1] = b;
    end else begin
      p_dly[idx] = b;
    end
    if (p_count < COUNT_TOP) p_count++;
  endfunction

  function automatic logic [2:0] count_bad(input logic [2:0] code);
    p_bad_run++;
    if (p_bad_run > p_limit) begin
      p_disc = 1'b1;
      return ST_TOO_MANY;
    end
    return code;
  endfunction

  function automatic logic [2:0] frame_verdict();
    logic [15:0] c;
    if (p_count < MIN_CRC_LEN || !p_proto_ok) return count_bad(ST_BAD_FORMAT);
    // The held CRC is little-endian, so the last byte goes in first.
    c = crc16_next(crc16_next(p_crc, p_dly[1]), p_dly[0]);
    if (c != 16'h0000) return count_bad(ST_BAD_CRC);
    p_bad_run = 0;
    if (p_count < HDR_OVERHEAD || !p_disp_ok) return ST_NOT_MSG;
    if (p_count != int'(p_len) + HDR_OVERHEAD) return ST_BAD_LEN;
    return ST_OK;
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    if (p_disc) return;
    if (p_esc) begin
      p_esc = 1'b0;
      append_unstuffed(b ^ ESC_XOR);
      return;
    end
    if (b == BYTE_ESC) begin
      p_esc = 1'b1;
      return;
    end
    if (b == BYTE_FLAG) begin
      if (p_count != 0) begin
        add_status(frame_verdict());
        clear_frame();
      end
      return;
    end
    if (p_count > p_max_len) begin
      p_disc = 1'b1;
      add_status(ST_OVERLONG);
      clear_frame();
      return;
    end
    append_unstuffed(b);
  endfunction

  function automatic byte_q_t with_crc(input byte_q_t d);
    logic [15:0] c;
    c = 16'h0000;
    foreach (d[i]) c = crc16_next(c, d[i]);
    d.push_back(c[7:0]);
    d.push_back(c[15:8]);
    return d;
  endfunction

  function automatic byte_q_t build_frame(input logic [7:0] proto, input logic [7:0] disp,
                                          input int n, input logic [7:0] len_field);
    byte_q_t d;
    d.push_back(proto);
    d.push_back(disp);
    repeat (4) d.push_back(8'($urandom));
    d.push_back(len_field);
    repeat (2 + n) d.push_back(8'($urandom));
    return with_crc(d);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    do v = 8'($urandom); while (v == BYTE_FLAG || v == BYTE_ESC);
    return v;
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic string fmt_result(input hfmr_result_t r);
    return $sformatf("kind=%0d byte=%02h status=%0d dest=%04h src=%04h group=%02h type=%02h len=%02h last=%0d",
                     r.item_kind, r.payload_byte, r.frame_status, r.dest_addr, r.source_addr,
                     r.group_id, r.msg_type, r.payload_length, r.last);
  endfunction

  function automatic bit same_result(input hfmr_result_t a, input hfmr_result_t b);
    return a.item_kind === b.item_kind && a.payload_byte === b.payload_byte &&
           a.frame_status === b.frame_status && a.dest_addr === b.dest_addr &&
           a.source_addr === b.source_addr && a.group_id === b.group_id &&
           a.msg_type === b.msg_type && a.payload_length === b.payload_length &&
           a.last === b.last;
  endfunction

  // Push stays high after acceptance; the next call either reuses it or drops it.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push    <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_full);
    sent_bytes++;
    predict_byte(b);
  endtask

  task automatic send_frame(input byte_q_t d, input int esc_from, input int esc_pct);
    foreach (d[i]) begin
      if (d[i] == BYTE_FLAG || d[i] == BYTE_ESC || i >= esc_from ||
          $urandom_range(0, 99) < esc_pct) begin
        send_byte(BYTE_ESC);
        send_byte(d[i] ^ ESC_XOR);
      end else begin
        send_byte(d[i]);
      end
    end
    send_byte(BYTE_FLAG);
  endtask

  // Bytes that produce nothing may still be in flight when the last result pops.
  task automatic wait_quiet();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MAX_LEN) p_max_len = val % (1 << MAXLEN_W);
    else p_limit = val % (1 << LIMIT_W);
  endtask

  task automatic set_regs(input int max_len, input int limit);
    wait_quiet();
    write_reg(CFG_MAX_LEN, max_len);
    write_reg(CFG_BAD_LIMIT, limit);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_frame_edges();
    byte_q_t d;
    send_byte(BYTE_FLAG);
    send_byte(PROTO_BYTE);
    send_byte(BYTE_FLAG);
    d = '{PROTO_BYTE, DISPATCH_BYTE, BYTE_FLAG, BYTE_ESC, 8'h00, 8'hFF, 8'h01, 8'hFF, 8'h00,
          BYTE_FLAG};
    send_frame(with_crc(d), NO_FORCED_ESC, 0);
    // An escape just before a delimiter turns the delimiter into data.
    send_byte(PROTO_BYTE);
    send_byte(BYTE_ESC);
    send_byte(BYTE_FLAG);
    send_byte(BYTE_FLAG);
  endtask

  task automatic test_escaped_length();
    set_regs(16, 255);
    // Escaped bytes are never checked against the length limit.
    send_frame(build_frame(PROTO_BYTE, DISPATCH_BYTE, 13, 8'd13), 14, 0);
    send_frame(build_frame(PROTO_BYTE, DISPATCH_BYTE, 6, 8'd6), NO_FORCED_ESC, 0);
  endtask

  task automatic test_count_saturation();
    set_regs(1023, 100);
    send_frame(build_frame(PROTO_BYTE, DISPATCH_BYTE, 255, 8'd255), NO_FORCED_ESC, 0);
    send_frame(build_frame(PROTO_BYTE, DISPATCH_BYTE, 1019, 8'($urandom)), NO_FORCED_ESC, 0);
  endtask

  task automatic test_random_frames();
    int         target;
    int         n;
    int         r;
    int         noise_len;
    shape_t     shape;
    byte_q_t    d;
    logic [7:0] lf;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_regs(16, 255);
        1: set_regs(1023, 1);
        default: set_regs($urandom_range(16, 1023), $urandom_range(1, 255));
      endcase
      target = sent_bytes + RANDOM_BYTES / 4;
      while (sent_bytes < target) begin
        r = $urandom_range(0, 99);
        if (r < 50) shape = SHAPE_GOOD;
        else if (r < 60) shape = SHAPE_NOT_MSG;
        else if (r < 66) shape = SHAPE_SHORT;
        else if (r < 74) shape = SHAPE_BAD_LEN;
        else if (r < 84) shape = SHAPE_BAD_CRC;
        else if (r < 89) shape = SHAPE_BAD_PROTO;
        else if (r < 96) shape = SHAPE_NOISE;
        else shape = SHAPE_EMPTY;
        // Disconnecting here would silence the rest of the run, so stay under the limit.
        noise_len = $urandom_range(1, 6);
        if ((shape == SHAPE_BAD_CRC || shape == SHAPE_BAD_PROTO) && p_bad_run + 1 > p_limit)
          shape = SHAPE_GOOD;
        if (shape == SHAPE_NOISE && p_bad_run + noise_len + 1 > p_limit) shape = SHAPE_GOOD;
        n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom_range(0, 40);
        if (n > p_max_len - HDR_OVERHEAD) n = p_max_len - HDR_OVERHEAD;
        d.delete();
        case (shape)
          SHAPE_GOOD: d = build_frame(PROTO_BYTE, DISPATCH_BYTE, n, 8'(n));
          SHAPE_NOT_MSG: d = build_frame(PROTO_BYTE, 8'($urandom_range(1, 255)), n, 8'(n));
          SHAPE_BAD_LEN: begin
            lf = 8'($urandom);
            if (lf == 8'(n)) lf = ~lf;
            d = build_frame(PROTO_BYTE, DISPATCH_BYTE, n, lf);
          end
          SHAPE_BAD_CRC: begin
            d = build_frame(PROTO_BYTE, DISPATCH_BYTE, n, 8'(n));
            r = $urandom_range(0, d.size() - 1);
            d[r] = d[r] ^ (8'h01 << $urandom_range(0, 7));
          end
          SHAPE_BAD_PROTO: begin
            lf = 8'($urandom);
            if (lf == PROTO_BYTE) lf = ~lf;
            d = build_frame(lf, DISPATCH_BYTE, n, 8'(n));
          end
          SHAPE_SHORT: begin
            d.push_back(PROTO_BYTE);
            repeat ($urandom_range(0, 7)) d.push_back(8'($urandom));
            d = with_crc(d);
          end
          default: ;
        endcase
        if (shape == SHAPE_NOISE) begin
          repeat (noise_len) begin
            if ($urandom_range(0, 4) == 0) send_byte($urandom_range(0, 1) ? BYTE_FLAG : BYTE_ESC);
            else send_byte(8'($urandom));
          end
          if (p_esc) send_byte(8'h00);
          send_byte(BYTE_FLAG);
        end else if (shape == SHAPE_EMPTY) begin
          send_byte(BYTE_FLAG);
        end else begin
          send_frame(d, NO_FORCED_ESC, 8);
        end
      end
    end
  endtask

  // Disconnection is sticky until reset, so only one of the two causes fits in a run.
  task automatic test_disconnect();
    if ($urandom_range(0, 1) == 1) begin
      set_regs($urandom_range(16, 40), 255);
      while (!p_disc) send_byte(plain_byte());
    end else begin
      set_regs(1000, $urandom_range(1, 4));
      while (!p_disc) begin
        send_byte(plain_byte());
        send_byte(BYTE_FLAG);
      end
    end
    repeat (20) send_byte(8'($urandom));
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_pop    <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      if ($urandom_range(0, 39) == 0) out_calm <= !out_calm;
      out_pop    <= 1'b1;
      stall_left <= pick_gap(out_calm);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      got_item = {out_item_kind, out_payload_byte, out_frame_status, out_dest_addr,
                  out_source_addr, out_group_id, out_msg_type, out_payload_length, out_last};
      if (pending_results.size() == 0) begin
        if (fail_count < 10) $display("result with none pending: %s", fmt_result(got_item));
        fail_count++;
      end else begin
        want_item = pending_results.pop_front();
        if (!same_result(want_item, got_item)) begin
          if (fail_count < 10) begin
            $display("mismatch, expected %s", fmt_result(want_item));
            $display("           actual %s", fmt_result(got_item));
          end
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("hdlc_framed_message_receiver_core test failed");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_frame_edges();
    test_escaped_length();
    test_count_saturation();
    test_random_frames();
    test_disconnect();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("hdlc_framed_message_receiver_core test passed");
    end else begin
      $display("hdlc_framed_message_receiver_core test failed");
    end
    $finish;
  end

endmodule
